// File: rtl/core/kph64_pkg.sv
// shared types, constants and schedule lookup for the 64-bit key password hash
`default_nettype none

package kph64_pkg;

   localparam int NumSteps = 34;
   localparam int StepW    = 6;

   localparam logic [StepW-1:0] LAST_STEP = StepW'(NumSteps - 1);

   typedef logic [3:0][31:0] words_type;

   typedef enum logic [1:0] {
      FN_CHOOSE = 2'd0,
      FN_MAJ    = 2'd2,
      FN_XOR    = 2'd3
   } fn_type;

   typedef enum logic [1:0] {
      INS_NONE = 2'd0,
      INS_HI   = 2'd1,
      INS_LO   = 2'd2
   } ins_type;

   typedef enum logic {
      OP_RENEW   = 1'b0,
      OP_ITERATE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS0,
      ST_PASS1,
      ST_COMBINE,
      ST_DONE
   } state_type;

   typedef struct packed {
      fn_type     fn;
      ins_type    ins;
      logic [4:0] rot;
      logic       mixb;
   } step_type;

   typedef struct packed {
      logic        start;
      logic [63:0] seed;
   } core_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } core_rsp_type;

   // initial words, word 0 in the low slot
   localparam words_type INIT_A = {32'h15A4D042, 32'hF67CCBB8, 32'h854C7A31, 32'h4503114F};
   localparam words_type INIT_B = {32'hD80D441C, 32'h95DE627A, 32'hB12E8FB5, 32'h519B4914};

   localparam logic [31:0] K_CHOOSE_B = 32'h50A28BE6;
   localparam logic [31:0] K_MAJ_A    = 32'h5A827999;
   localparam logic [31:0] K_XOR_A    = 32'h6ED9EBA1;
   localparam logic [31:0] K_XOR_B    = 32'h5C4DD124;
   localparam logic [31:0] C_X        = 32'hEFCDAB89;
   localparam logic [31:0] C_Y        = 32'h98BADCFE;

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   function automatic step_type sched_step(input logic [StepW-1:0] idx);
      case (idx)
         6'd0:    return '{FN_CHOOSE, INS_HI,   5'd1,  1'b0};
         6'd1:    return '{FN_CHOOSE, INS_LO,   5'd0,  1'b0};
         6'd2:    return '{FN_MAJ,    INS_NONE, 5'd31, 1'b0};
         6'd3:    return '{FN_MAJ,    INS_NONE, 5'd30, 1'b0};
         6'd4:    return '{FN_MAJ,    INS_NONE, 5'd0,  1'b0};
         6'd5:    return '{FN_MAJ,    INS_NONE, 5'd29, 1'b1};
         6'd6:    return '{FN_MAJ,    INS_NONE, 5'd3,  1'b0};
         6'd7:    return '{FN_MAJ,    INS_NONE, 5'd1,  1'b0};
         6'd8:    return '{FN_MAJ,    INS_LO,   5'd31, 1'b0};
         6'd9:    return '{FN_MAJ,    INS_NONE, 5'd31, 1'b1};
         6'd10:   return '{FN_MAJ,    INS_NONE, 5'd31, 1'b0};
         6'd11:   return '{FN_MAJ,    INS_NONE, 5'd4,  1'b0};
         6'd12:   return '{FN_MAJ,    INS_NONE, 5'd31, 1'b1};
         6'd13:   return '{FN_MAJ,    INS_NONE, 5'd1,  1'b0};
         6'd14:   return '{FN_MAJ,    INS_HI,   5'd31, 1'b0};
         6'd15:   return '{FN_MAJ,    INS_NONE, 5'd3,  1'b0};
         6'd16:   return '{FN_MAJ,    INS_NONE, 5'd29, 1'b1};
         6'd17:   return '{FN_MAJ,    INS_NONE, 5'd4,  1'b0};
         6'd18:   return '{FN_XOR,    INS_NONE, 5'd3,  1'b0};
         6'd19:   return '{FN_XOR,    INS_NONE, 5'd29, 1'b1};
         6'd20:   return '{FN_XOR,    INS_NONE, 5'd30, 1'b1};
         6'd21:   return '{FN_XOR,    INS_NONE, 5'd31, 1'b0};
         6'd22:   return '{FN_XOR,    INS_NONE, 5'd30, 1'b1};
         6'd23:   return '{FN_XOR,    INS_LO,   5'd1,  1'b0};
         6'd24:   return '{FN_XOR,    INS_NONE, 5'd29, 1'b1};
         6'd25:   return '{FN_XOR,    INS_NONE, 5'd31, 1'b1};
         6'd26:   return '{FN_XOR,    INS_HI,   5'd30, 1'b0};
         6'd27:   return '{FN_XOR,    INS_NONE, 5'd0,  1'b0};
         6'd28:   return '{FN_XOR,    INS_NONE, 5'd29, 1'b1};
         6'd29:   return '{FN_XOR,    INS_NONE, 5'd30, 1'b0};
         6'd30:   return '{FN_XOR,    INS_NONE, 5'd4,  1'b0};
         6'd31:   return '{FN_XOR,    INS_NONE, 5'd29, 1'b0};
         6'd32:   return '{FN_XOR,    INS_NONE, 5'd31, 1'b0};
         6'd33:   return '{FN_XOR,    INS_NONE, 5'd29, 1'b0};
         default: return '{FN_XOR,    INS_NONE, 5'd0,  1'b0};
      endcase
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/kph64_step.sv
// one schedule step: boolean function, additions, rotate and word permutation
`default_nettype none

module kph64_step (
   input  var kph64_pkg::words_type       words,
   input  var logic                       sel,
   input  var logic [kph64_pkg::StepW-1:0] step_idx,
   input  var logic [63:0]                seed,
   output     kph64_pkg::words_type       words_next
);
   import kph64_pkg::*;

   step_type    st;
   logic [31:0] a;
   logic [31:0] b;
   logic [31:0] c;
   logic [31:0] f;
   logic [31:0] k;
   logic [31:0] ins_val;
   logic [31:0] sum;
   logic [31:0] t;

   always_comb begin
      st = sched_step(step_idx);
      a  = words[0];
      b  = words[1];
      c  = words[3];
      case (st.fn)
         FN_CHOOSE: begin
            f = ((a ^ b) & c) ^ b;
            k = sel ? K_CHOOSE_B : 32'd0;
         end
         FN_MAJ: begin
            f = (a & b) | ((a | b) & c);
            k = sel ? 32'd0 : K_MAJ_A;
         end
         FN_XOR: begin
            f = a ^ b ^ c;
            k = sel ? K_XOR_B : K_XOR_A;
         end
         default: begin
            f = a ^ b ^ c;
            k = sel ? K_XOR_B : K_XOR_A;
         end
      endcase
      case (st.ins)
         INS_HI:  ins_val = bswap32(seed[63:32]);
         INS_LO:  ins_val = bswap32(seed[31:0]);
         default: ins_val = 32'd0;
      endcase
      sum = words[2] + f + k + ins_val;
      t   = rotl32(sum, st.rot);
      words_next[2] = words[1];
      words_next[1] = words[0];
      words_next[0] = words[3];
      words_next[3] = rotl32(t, st.mixb ? 5'd16 : 5'd8);
   end

endmodule

`default_nettype wire

// File: rtl/core/kph64_core.sv
// sequencer running both half-passes through the shared step unit, then the combine
`default_nettype none

module kph64_core (
   input  var logic                    clock,
   input  var logic                    reset,
   input  var kph64_pkg::core_cmd_type cmd,
   output     kph64_pkg::core_rsp_type rsp
);
   import kph64_pkg::*;

   state_type        state_ff,  state_in;
   logic [StepW-1:0] step_ff,   step_in;
   words_type        w_ff,      w_in;
   logic [31:0]      a0_ff,     a0_in;
   logic [31:0]      a1_ff,     a1_in;
   logic [63:0]      seed_ff,   seed_in;
   logic [63:0]      result_ff, result_in;
   words_type        w_step;
   logic [31:0]      x;
   logic [31:0]      y;

   kph64_step u_step (
      .words      (w_ff),
      .sel        (state_ff == ST_PASS1),
      .step_idx   (step_ff),
      .seed       (seed_ff),
      .words_next (w_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      w_ff      <= w_in;
      a0_ff     <= a0_in;
      a1_ff     <= a1_in;
      seed_ff   <= seed_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      w_in      = w_ff;
      a0_in     = a0_ff;
      a1_in     = a1_ff;
      seed_in   = seed_ff;
      result_in = result_ff;
      x         = a0_ff + w_ff[1] + C_X;
      y         = a1_ff + w_ff[2] + C_Y;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (cmd.start) begin
               seed_in  = cmd.seed;
               w_in     = INIT_A;
               step_in  = '0;
               state_in = ST_PASS0;
            end
         end
         ST_PASS0: begin
            w_in    = w_step;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               a0_in    = w_step[0];
               a1_in    = w_step[1];
               w_in     = INIT_B;
               step_in  = '0;
               state_in = ST_PASS1;
            end
         end
         ST_PASS1: begin
            w_in    = w_step;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_COMBINE;
            end
         end
         ST_COMBINE: begin
            result_in = {bswap32(x), bswap32(y)};
            state_in  = ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp.done   = (state_ff == ST_DONE);
      rsp.result = result_ff;
   end

endmodule

`default_nettype wire

// File: rtl/core/key_password_hash_64_top.sv
// Key password hash, 64-bit. One request gives one response. Renew (op 0)
// hashes seed_word ^ mix_word once and xors out_mask into the result; iterate
// (op 1) chains the hash iterations times, feeding each result back as the
// seed (zero iterations returns seed_word). Every hash pass goes through a
// single shared 32-bit step unit: a launch from the top level, 34 steps of
// half-pass 0, 34 of half-pass 1, a combine, and the pick-up of the finished
// pass by the top level. req_stall is high for the whole job. The response
// register lets the next request be taken while a finished response still
// waits on rsp_stall.
`default_nettype none

module key_password_hash_64_top (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_valid,
   output     logic        req_stall,
   input  var logic        req_op,
   input  var logic [63:0] req_seed_word,
   input  var logic [63:0] req_mix_word,
   input  var logic [63:0] req_out_mask,
   input  var logic [15:0] req_iterations,
   output     logic        rsp_valid,
   input  var logic        rsp_stall,
   output     logic [63:0] rsp_hash_value
);
   import kph64_pkg::*;

   logic         busy_ff,      busy_in;
   logic         launch_ff,    launch_in;
   logic [15:0]  count_ff,     count_in;
   logic [63:0]  seed_ff,      seed_in;
   logic [63:0]  mask_ff,      mask_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_data_ff,  rsp_data_in;
   core_cmd_type core_cmd;
   core_rsp_type core_rsp;
   logic         req_take;
   logic         out_free;
   logic         pass_done;
   logic         finish;

   kph64_core u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (core_cmd),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff    <= count_in;
      seed_ff     <= seed_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      busy_in      = busy_ff;
      launch_in    = 1'b0;
      count_in     = count_ff;
      seed_in      = seed_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      req_take  = req_valid && !busy_ff;
      out_free  = !rsp_valid_ff || !rsp_stall;
      pass_done = busy_ff && !launch_ff && core_rsp.done;
      finish    = busy_ff && !launch_ff &&
                  ((count_ff == 16'd0) || (pass_done && count_ff == 16'd1));

      // response register frees on transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_take) begin
         busy_in = 1'b1;
         if (req_op == OP_ITERATE) begin
            seed_in   = req_seed_word;
            count_in  = req_iterations;
            mask_in   = '0;
            launch_in = (req_iterations != 16'd0);
         end else begin
            seed_in   = req_seed_word ^ req_mix_word;
            count_in  = 16'd1;
            mask_in   = req_out_mask;
            launch_in = 1'b1;
         end
      end else if (finish) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ((count_ff == 16'd0) ? seed_ff : core_rsp.result) ^ mask_ff;
            busy_in      = 1'b0;
         end
      end else if (pass_done && count_ff > 16'd1) begin
         seed_in   = core_rsp.result;
         count_in  = count_ff - 16'd1;
         launch_in = 1'b1;
      end

      core_cmd.start = launch_ff;
      core_cmd.seed  = seed_ff;
   end

   assign req_stall      = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/kph64_checker.sv
// port-level checks for the key password hash top level, with bind
`default_nettype none

module kph64_checker (
   input var logic        clock,
   input var logic        reset,
   input var logic        req_valid,
   input var logic        req_stall,
   input var logic        req_op,
   input var logic [15:0] req_iterations,
   input var logic        rsp_valid,
   input var logic        rsp_stall,
   input var logic [63:0] rsp_hash_value
);
   import kph64_pkg::*;

   logic req_xfer;
   logic hashing_req;

   assign req_xfer    = req_valid && !req_stall;
   assign hashing_req = (req_op == OP_RENEW) || (req_iterations != 16'd0);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_hash_value))
      else $error("rsp_hash_value changed while stalled");

   // one job at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while a job is running");

   // a hash pass cannot finish right after the request transfer
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && hashing_req && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("response appeared too early after a hashing request");

endmodule

bind key_password_hash_64_top kph64_checker u_kph64_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_op         (req_op),
   .req_iterations (req_iterations),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);

`default_nettype wire
